### src/pde_pkg.sv
// Shared types, constants and the sequencer control store for the Playfair encryptor.
`timescale 1ns / 1ps
`default_nettype none

package pde_pkg;

    // Letter codes and square geometry
    localparam logic [4:0] LETTER_I   = 5'd8;
    localparam logic [4:0] LETTER_J   = 5'd9;
    localparam logic [4:0] LETTER_Z   = 5'd25;
    localparam logic [4:0] CELL_COUNT = 5'd25;
    localparam logic [2:0] SIDE_LAST  = 3'd4;

    // Command codes carried in tuser
    typedef enum logic [1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_KEY     = 2'd1,
        CMD_KEY_END = 2'd2,
        CMD_ENCRYPT = 2'd3
    } cmd_t;

    // Datapath action of one control word
    typedef enum logic [2:0] {
        ACT_NONE      = 3'd0,
        ACT_CLEAR     = 3'd1,
        ACT_PLACE_IN  = 3'd2,
        ACT_K_ZERO    = 3'd3,
        ACT_PLACE_K   = 3'd4,
        ACT_SET_READY = 3'd5,
        ACT_READ_POS  = 3'd6,
        ACT_READ_SQ   = 3'd7
    } act_t;

    // Result loaded into the output register; RES_NONE loads nothing
    typedef enum logic [1:0] {
        RES_NONE   = 2'd0,
        RES_ZERO   = 2'd1,
        RES_ERR    = 2'd2,
        RES_CIPHER = 2'd3
    } res_t;

    // Sequencing condition
    typedef enum logic [2:0] {
        JMP_NEXT      = 3'd0,  // step + 1
        JMP_GOTO      = 3'd1,  // always to target
        JMP_DISPATCH  = 3'd2,  // on transfer, by command; else hold
        JMP_K_LAST    = 3'd3,  // walk counter at z: target; else hold
        JMP_NOT_READY = 3'd4,  // square not ready: target; else step + 1
        JMP_OUT_FREE  = 3'd5   // output register free: target; else hold
    } jmp_t;

    typedef logic [3:0] step_t;

    // Control store addresses
    localparam step_t STEP_FETCH    = 4'd0;
    localparam step_t STEP_CLEAR    = 4'd1;
    localparam step_t STEP_KEY      = 4'd2;
    localparam step_t STEP_END_INIT = 4'd3;
    localparam step_t STEP_END_WALK = 4'd4;
    localparam step_t STEP_END_DONE = 4'd5;
    localparam step_t STEP_ENC_POS  = 4'd6;
    localparam step_t STEP_ENC_SQ   = 4'd7;
    localparam step_t STEP_EMIT_ENC = 4'd8;
    localparam step_t STEP_EMIT_Z   = 4'd9;
    localparam step_t STEP_EMIT_ERR = 4'd10;

    typedef struct packed {
        act_t  act;
        res_t  res;
        jmp_t  jmp;
        step_t target;
    } ctl_word_t;

    // Microprogram
    function automatic ctl_word_t ucode_rom(input step_t addr);
        ctl_word_t w;
        w = '{act: ACT_NONE, res: RES_NONE, jmp: JMP_GOTO, target: STEP_FETCH};
        case (addr)
            STEP_FETCH:    w = '{ACT_NONE,      RES_NONE,   JMP_DISPATCH,  STEP_FETCH};
            STEP_CLEAR:    w = '{ACT_CLEAR,     RES_NONE,   JMP_GOTO,      STEP_EMIT_Z};
            STEP_KEY:      w = '{ACT_PLACE_IN,  RES_NONE,   JMP_GOTO,      STEP_EMIT_Z};
            STEP_END_INIT: w = '{ACT_K_ZERO,    RES_NONE,   JMP_NEXT,      STEP_FETCH};
            STEP_END_WALK: w = '{ACT_PLACE_K,   RES_NONE,   JMP_K_LAST,    STEP_END_DONE};
            STEP_END_DONE: w = '{ACT_SET_READY, RES_NONE,   JMP_GOTO,      STEP_EMIT_Z};
            STEP_ENC_POS:  w = '{ACT_READ_POS,  RES_NONE,   JMP_NOT_READY, STEP_EMIT_ERR};
            STEP_ENC_SQ:   w = '{ACT_READ_SQ,   RES_NONE,   JMP_NEXT,      STEP_FETCH};
            STEP_EMIT_ENC: w = '{ACT_NONE,      RES_CIPHER, JMP_OUT_FREE,  STEP_FETCH};
            STEP_EMIT_Z:   w = '{ACT_NONE,      RES_ZERO,   JMP_OUT_FREE,  STEP_FETCH};
            STEP_EMIT_ERR: w = '{ACT_NONE,      RES_ERR,    JMP_OUT_FREE,  STEP_FETCH};
            default:       w = '{ACT_NONE,      RES_NONE,   JMP_GOTO,      STEP_FETCH};
        endcase
        return w;
    endfunction

    // Entry step for each command
    function automatic step_t dispatch_rom(input cmd_t cmd);
        step_t s;
        s = STEP_FETCH;
        unique case (cmd)
            CMD_CLEAR:   s = STEP_CLEAR;
            CMD_KEY:     s = STEP_KEY;
            CMD_KEY_END: s = STEP_END_INIT;
            CMD_ENCRYPT: s = STEP_ENC_POS;
            default:     s = STEP_FETCH;
        endcase
        return s;
    endfunction

    // Pair letter: above z reads as z, j reads as i
    function automatic logic [4:0] pair_letter(input logic [4:0] x);
        logic [4:0] y;
        y = (x > LETTER_Z) ? LETTER_Z : x;
        return (y == LETTER_J) ? LETTER_I : y;
    endfunction

    // Row of a cell 0..24: floor(pos * 13 / 64) equals pos / 5 on that range
    function automatic logic [2:0] row_of(input logic [4:0] pos);
        logic [8:0] p;
        p = {4'b0, pos} * 9'd13;
        return p[8:6];
    endfunction

    function automatic logic [2:0] col_of(input logic [4:0] pos, input logic [2:0] row);
        logic [4:0] c;
        c = pos - ({2'b0, row} * 5'd5);
        return c[2:0];
    endfunction

    function automatic logic [2:0] wrap_inc(input logic [2:0] v);
        return (v == SIDE_LAST) ? 3'd0 : 3'(v + 3'd1);
    endfunction

    function automatic logic [4:0] cell_of(input logic [2:0] row, input logic [2:0] col);
        return 5'({2'b0, row} * 5'd5 + {2'b0, col});
    endfunction

endpackage

`default_nettype wire

### src/playfair_digraph_encryptor_core.sv
// Top level: microcoded Playfair key-square builder and digraph encryptor.
`timescale 1ns / 1ps
`default_nettype none

// Each input transfer carries a command in s_tuser and letters in s_tdata; every command
// returns exactly one result. A sequencer steps one control word per cycle, holding in the
// fetch step for an input transfer and in a result load for a free output register. A clear
// or key letter runs its action then a result load; an encrypt pair a position-map read, a
// key-square read and a result load, each registered; a key end walks the 26 letters at one
// letter per cycle. Results wait in an output register; a command is taken while an older
// result is still waiting, and only its own result load holds for the output side. Encrypting
// before a key end returns status 1 with zero letters; other commands return all zeros.
module playfair_digraph_encryptor_core (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [15:0] s_tdata,   // [4:0] first_letter, [9:5] second_letter, [15:10] zero
    input  wire  [1:0]  s_tuser,   // [1:0] cmd
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata,   // [4:0] first_out, [9:5] second_out, [15:10] zero
    output logic [0:0]  m_tuser    // [0] status
);

    // Sequencer state
    pde_pkg::step_t     step_reg, step_next;
    pde_pkg::ctl_word_t cw;

    // Key-square build state
    logic [25:0] seen_reg;
    logic [4:0]  fill_reg;
    logic        ready_reg;
    logic [4:0]  k_reg;

    // Latched pair / key letters
    logic [4:0]  a_reg, b_reg;

    // Memories and their registered read data
    logic [4:0]  key_square   [25];
    logic [4:0]  letter_pos   [26];
    logic [4:0]  pos_a_reg, pos_b_reg;
    logic [4:0]  sq_a_reg, sq_b_reg;

    // Output register
    logic        out_valid_reg;
    logic [4:0]  out_a_reg, out_b_reg;
    logic        out_st_reg;

    logic        in_xfer, out_free, emit;
    logic [4:0]  place_letter;
    logic        place_req, place_en;
    logic [2:0]  ra, ca, rb, cb;
    logic [4:0]  oa, ob;

    assign cw       = pde_pkg::ucode_rom(step_reg);
    assign s_tready = (step_reg == pde_pkg::STEP_FETCH);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign emit     = (cw.res != pde_pkg::RES_NONE) && out_free;

    // Next step
    always_comb
    begin
        step_next = step_reg;
        unique case (cw.jmp)
            pde_pkg::JMP_NEXT:      step_next = pde_pkg::step_t'(step_reg + 4'd1);
            pde_pkg::JMP_GOTO:      step_next = cw.target;
            pde_pkg::JMP_DISPATCH:
                if (in_xfer)
                    step_next = pde_pkg::dispatch_rom(pde_pkg::cmd_t'(s_tuser));
            pde_pkg::JMP_K_LAST:
                if (k_reg == pde_pkg::LETTER_Z)
                    step_next = cw.target;
            pde_pkg::JMP_NOT_READY:
                step_next = ready_reg ? pde_pkg::step_t'(step_reg + 4'd1) : cw.target;
            pde_pkg::JMP_OUT_FREE:
                if (out_free)
                    step_next = cw.target;
            default:                step_next = pde_pkg::STEP_FETCH;
        endcase
    end

    // Letter placement: key letter from the input, or the key-end walk counter
    always_comb
    begin
        place_letter = (cw.act == pde_pkg::ACT_PLACE_IN) ? a_reg : k_reg;
        place_req    = ((cw.act == pde_pkg::ACT_PLACE_IN) && !ready_reg) ||
                       (cw.act == pde_pkg::ACT_PLACE_K);
        place_en     = place_req && (place_letter != pde_pkg::LETTER_J) &&
                       (place_letter <= pde_pkg::LETTER_Z) &&
                       (fill_reg < pde_pkg::CELL_COUNT) && !seen_reg[place_letter];
    end

    // Cipher cell addresses from the registered positions
    always_comb
    begin
        ra = pde_pkg::row_of(pos_a_reg);
        rb = pde_pkg::row_of(pos_b_reg);
        ca = pde_pkg::col_of(pos_a_reg, ra);
        cb = pde_pkg::col_of(pos_b_reg, rb);
        if (ra == rb)
        begin
            oa = pde_pkg::cell_of(ra, pde_pkg::wrap_inc(ca));
            ob = pde_pkg::cell_of(rb, pde_pkg::wrap_inc(cb));
        end
        else if (ca == cb)
        begin
            oa = pde_pkg::cell_of(pde_pkg::wrap_inc(ra), ca);
            ob = pde_pkg::cell_of(pde_pkg::wrap_inc(rb), cb);
        end
        else
        begin
            oa = pde_pkg::cell_of(ra, cb);
            ob = pde_pkg::cell_of(rb, ca);
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= pde_pkg::STEP_FETCH;
            seen_reg      <= '0;
            fill_reg      <= '0;
            ready_reg     <= 1'b0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            case (cw.act)
                pde_pkg::ACT_CLEAR:
                begin
                    seen_reg  <= '0;
                    fill_reg  <= '0;
                    ready_reg <= 1'b0;
                end
                pde_pkg::ACT_K_ZERO:    k_reg <= '0;
                pde_pkg::ACT_SET_READY: ready_reg <= 1'b1;
                default: ;
            endcase
            if (cw.act == pde_pkg::ACT_PLACE_K)
                k_reg <= 5'(k_reg + 5'd1);
            if (place_en)
            begin
                seen_reg[place_letter] <= 1'b1;
                fill_reg               <= 5'(fill_reg + 5'd1);
            end
            if (emit)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Memories, input latch and output payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            a_reg <= s_tdata[4:0];
            b_reg <= s_tdata[9:5];
        end
        if (place_en)
        begin
            key_square[fill_reg]     <= place_letter;
            letter_pos[place_letter] <= fill_reg;
        end
        if (cw.act == pde_pkg::ACT_READ_POS)
        begin
            pos_a_reg <= letter_pos[pde_pkg::pair_letter(a_reg)];
            pos_b_reg <= letter_pos[pde_pkg::pair_letter(b_reg)];
        end
        if (cw.act == pde_pkg::ACT_READ_SQ)
        begin
            sq_a_reg <= key_square[oa];
            sq_b_reg <= key_square[ob];
        end
        if (emit)
        begin
            out_a_reg  <= (cw.res == pde_pkg::RES_CIPHER) ? sq_a_reg : 5'd0;
            out_b_reg  <= (cw.res == pde_pkg::RES_CIPHER) ? sq_b_reg : 5'd0;
            out_st_reg <= (cw.res == pde_pkg::RES_ERR);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_b_reg, out_a_reg};
    assign m_tuser  = out_st_reg;

endmodule

`default_nettype wire

### src/pde_checker.sv
// Port-level assertions for the Playfair encryptor, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module pde_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        s_tvalid,
    input wire        s_tready,
    input wire [15:0] s_tdata,
    input wire [1:0]  s_tuser,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [15:0] m_tdata,
    input wire [0:0]  m_tuser
);

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // One command at a time: the input closes right after a transfer
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input open in the cycle after a transfer");

    // An error result carries no letters
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == 16'd0)
        else $error("error result with nonzero letters");

    // Cipher letters are letter codes and the pad stays zero
    a_letters: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[4:0] <= 5'd25 && m_tdata[9:5] <= 5'd25 &&
                     m_tdata[15:10] == 6'd0)
        else $error("result letter out of range");

    // A result only follows an earlier input transfer
    a_no_idle_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared with no command in progress");

endmodule

bind playfair_digraph_encryptor_core pde_checker u_pde_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

### verif/tb.sv
// Self-checking testbench for the Playfair key-square builder and digraph encryptor.
`timescale 1ns / 1ps

module tb;

    localparam int CLK_PERIOD   = 20;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int ITEM_TARGET  = 1925;
    localparam int TAIL_CYCLES  = 40;
    localparam int SQUARE_CELLS = 25;
    localparam int ALPHABET     = 26;
    localparam int SQUARE_SIDE  = 5;

    // One result as seen on the output stream
    typedef struct packed {
        logic [4:0] first_out;
        logic [4:0] second_out;
        logic       status;
    } cipher_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [0:0]  m_tuser;

    // Predictor state
    logic [4:0]  sq_cells [SQUARE_CELLS];
    logic [4:0]  cell_of_letter [ALPHABET];
    logic [25:0] placed_mask = '0;
    int          cells_filled = 0;
    logic        square_ready = 1'b0;

    cipher_result_t pending_ciphers[$];
    int mismatches = 0;
    int items_sent = 0;
    int cycle_count = 0;
    int burst_left = 0;

    playfair_digraph_encryptor_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void add_to_square(input int letter);
        if (cells_filled >= SQUARE_CELLS || letter >= ALPHABET || placed_mask[letter])
            return;
        sq_cells[cells_filled]  = 5'(letter);
        cell_of_letter[letter]  = 5'(cells_filled);
        placed_mask[letter]     = 1'b1;
        cells_filled            = cells_filled + 1;
    endfunction

    // Pair letters: out-of-range reads as z, j reads as i
    function automatic int fold_letter(input logic [4:0] x);
        int v;
        v = (x > pde_pkg::LETTER_Z) ? int'(pde_pkg::LETTER_Z) : int'(x);
        if (v == int'(pde_pkg::LETTER_J))
            v = int'(pde_pkg::LETTER_I);
        return v;
    endfunction

    function automatic cipher_result_t predict_cipher(input pde_pkg::cmd_t cmd,
                                                      input logic [4:0] a_in,
                                                      input logic [4:0] b_in);
        cipher_result_t r;
        int pa, pb, ra, ca, rb, cb, oa, ob;
        r = '0;
        case (cmd)
            pde_pkg::CMD_CLEAR:
            begin
                placed_mask  = '0;
                cells_filled = 0;
                square_ready = 1'b0;
            end
            pde_pkg::CMD_KEY:
            begin
                if (!square_ready && a_in != pde_pkg::LETTER_J)
                    add_to_square(int'(a_in));
            end
            pde_pkg::CMD_KEY_END:
            begin
                for (int k = 0; k < ALPHABET; k++)
                    if (k != int'(pde_pkg::LETTER_J))
                        add_to_square(k);
                square_ready = 1'b1;
            end
            default:
            begin
                if (!square_ready)
                begin
                    r.status = 1'b1;
                end
                else
                begin
                    pa = int'(cell_of_letter[fold_letter(a_in)]);
                    pb = int'(cell_of_letter[fold_letter(b_in)]);
                    ra = pa / SQUARE_SIDE;
                    ca = pa % SQUARE_SIDE;
                    rb = pb / SQUARE_SIDE;
                    cb = pb % SQUARE_SIDE;
                    // doubled letters fall into the same-row rule
                    if (ra == rb)
                    begin
                        oa = ra * SQUARE_SIDE + (ca + 1) % SQUARE_SIDE;
                        ob = rb * SQUARE_SIDE + (cb + 1) % SQUARE_SIDE;
                    end
                    else if (ca == cb)
                    begin
                        oa = ((ra + 1) % SQUARE_SIDE) * SQUARE_SIDE + ca;
                        ob = ((rb + 1) % SQUARE_SIDE) * SQUARE_SIDE + cb;
                    end
                    else
                    begin
                        oa = ra * SQUARE_SIDE + cb;
                        ob = rb * SQUARE_SIDE + ca;
                    end
                    r.first_out  = sq_cells[oa];
                    r.second_out = sq_cells[ob];
                end
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    task automatic send_item(input pde_pkg::cmd_t cmd, input logic [4:0] a,
                             input logic [4:0] b);
        int gap;
        // bursts of random length separated by random gaps
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
            end
        end
        burst_left = burst_left - 1;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, b, a};
        s_tuser  <= cmd;
        do
            @(posedge clk);
        while (!s_tready);
        pending_ciphers.push_back(predict_cipher(cmd, a, b));
        items_sent++;
    endtask

    // Hold off the sender until every pending result has come back
    task automatic wait_drained();
        do
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        while (pending_ciphers.size() != 0);
        burst_left = 0;
    endtask

    function automatic logic [4:0] any_letter();
        return 5'($urandom_range(0, 31));
    endfunction

    // Mostly real letters, sometimes the out-of-range codes
    function automatic logic [4:0] pick_letter();
        if ($urandom_range(0, 7) == 0)
            return 5'($urandom_range(26, 31));
        return 5'($urandom_range(0, 25));
    endfunction

    // ------------------------------------------------------------------
    // Output side: stall pattern in windows of random length
    // ------------------------------------------------------------------
    initial
    begin
        int window;
        int mode;
        int phase;
        window = 0;
        mode = 0;
        phase = 0;
        forever
        begin
            @(negedge clk);
            if (window == 0)
            begin
                window = $urandom_range(8, 64);
                mode = $urandom_range(0, 3);
            end
            window = window - 1;
            phase = phase + 1;
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= (phase % 4 == 0);
            endcase
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        cipher_result_t got;
        cipher_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{first_out: m_tdata[4:0], second_out: m_tdata[9:5], status: m_tuser[0]};
            if (pending_ciphers.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result with nothing pending: first %0d second %0d status %0d",
                             got.first_out, got.second_out, got.status);
            end
            else
            begin
                want = pending_ciphers.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: first %0d/%0d second %0d/%0d status %0d/%0d (exp/act)",
                                 want.first_out, got.first_out, want.second_out,
                                 got.second_out, want.status, got.status);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_encrypt_without_key();
        send_item(pde_pkg::CMD_ENCRYPT, 5'd0, pde_pkg::LETTER_Z);
    endtask

    task automatic test_key_build();
        logic [4:0] key_letters [9];
        key_letters = '{5'd15, 5'd11, 5'd0, 5'd24, pde_pkg::LETTER_J, 5'd0, 5'd5, 5'd17,
                        5'd31};
        send_item(pde_pkg::CMD_CLEAR, 5'd0, 5'd0);
        foreach (key_letters[i])
            send_item(pde_pkg::CMD_KEY, key_letters[i], any_letter());
        send_item(pde_pkg::CMD_KEY_END, any_letter(), any_letter());
        // second key end and a late key letter leave the square alone
        send_item(pde_pkg::CMD_KEY_END, any_letter(), any_letter());
        send_item(pde_pkg::CMD_KEY, 5'd16, any_letter());
    endtask

    task automatic test_pair_rules();
        send_item(pde_pkg::CMD_ENCRYPT, sq_cells[0], sq_cells[3]);    // same row
        send_item(pde_pkg::CMD_ENCRYPT, sq_cells[4], sq_cells[2]);    // same row, wraps right
        send_item(pde_pkg::CMD_ENCRYPT, sq_cells[1], sq_cells[21]);   // same column, wraps down
        send_item(pde_pkg::CMD_ENCRYPT, sq_cells[6], sq_cells[18]);   // rectangle
        send_item(pde_pkg::CMD_ENCRYPT, sq_cells[24], sq_cells[24]);  // doubled letter
        send_item(pde_pkg::CMD_ENCRYPT, pde_pkg::LETTER_J, pde_pkg::LETTER_J);
        send_item(pde_pkg::CMD_ENCRYPT, 5'd31, 5'd26);
    endtask

    task automatic test_clear_then_encrypt();
        send_item(pde_pkg::CMD_CLEAR, 5'd31, 5'd31);
        send_item(pde_pkg::CMD_ENCRYPT, 5'd0, pde_pkg::LETTER_Z);
        // empty key: square is the plain alphabet
        send_item(pde_pkg::CMD_KEY_END, 5'd0, 5'd0);
        send_item(pde_pkg::CMD_ENCRYPT, pde_pkg::LETTER_Z, 5'd0);
    endtask

    task automatic test_random_sessions();
        int sessions;
        int kind;
        int n;
        sessions = 0;
        while (items_sent < ITEM_TARGET)
        begin
            kind = $urandom_range(0, 9);
            if (kind == 0)
            begin
                // noise: any command, any letters
                n = $urandom_range(1, 6);
                repeat (n)
                    send_item(pde_pkg::cmd_t'($urandom_range(0, 3)), any_letter(),
                              any_letter());
            end
            else if (kind == 1)
            begin
                // broken session: pairs before the key is finished
                send_item(pde_pkg::CMD_CLEAR, any_letter(), any_letter());
                n = $urandom_range(0, 5);
                repeat (n)
                    send_item(pde_pkg::CMD_KEY, pick_letter(), any_letter());
                n = $urandom_range(1, 4);
                repeat (n)
                    send_item(pde_pkg::CMD_ENCRYPT, any_letter(), any_letter());
                if ($urandom_range(0, 1) == 1)
                    send_item(pde_pkg::CMD_KEY_END, any_letter(), any_letter());
            end
            else
            begin
                // well-formed session: usually a clear, then key, key end, then a run of pairs
                if ($urandom_range(0, 9) != 0)
                    send_item(pde_pkg::CMD_CLEAR, any_letter(), any_letter());
                n = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 10);
                repeat (n)
                    send_item(pde_pkg::CMD_KEY, pick_letter(), any_letter());
                send_item(pde_pkg::CMD_KEY_END, any_letter(), any_letter());
                n = $urandom_range(4, 30);
                repeat (n)
                begin
                    send_item(pde_pkg::CMD_ENCRYPT, pick_letter(), pick_letter());
                    if ($urandom_range(0, 15) == 0)
                        send_item(pde_pkg::CMD_KEY, pick_letter(), any_letter());
                end
            end
            sessions++;
            if (sessions % 7 == 0)
                wait_drained();
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_encrypt_without_key();
        test_key_build();
        test_pair_rules();
        test_clear_then_encrypt();
        wait_drained();
        test_random_sessions();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_ciphers.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
